// ----- rtl/core/pcrc_pkg.sv -----
// Shared types and constants for the pointer candidate range check.
// Used by pcrc_ctrl, pcrc_dpath and pointer_candidate_range_check.
`timescale 1ns / 1ps

package pcrc_pkg;

  // Request kinds
  localparam logic [1:0] KIND_CLEAR    = 2'd0;
  localparam logic [1:0] KIND_ADD      = 2'd1;
  localparam logic [1:0] KIND_CLASSIFY = 2'd2;

  // Canonical user/kernel address form: top 16 bits all zero or all one
  localparam logic [63:0] HIGH_MASK = 64'hffff_0000_0000_0000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] region_start;
    logic [63:0] region_end;
    logic [63:0] query_value;
  } in_item_t;

  typedef struct packed {
    logic is_pointer;
    logic table_full;
  } out_item_t;

  // Table read address source
  typedef enum logic [1:0] {
    RD_POS_M1 = 2'd0,
    RD_MID    = 2'd1,
    RD_LO_M1  = 2'd2
  } rd_src_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load_in;   // capture request, init pointers and result
    logic    clear;     // empty the table
    logic    set_full;  // flag a rejected add
    logic    rd_en;     // read table entry
    rd_src_t rd_src;
    logic    shift;     // move read entry up one slot, pos--
    logic    put;       // write new region at pos, count++
    logic    step;      // binary search update of lo/hi
    logic    set_ptr;   // final range check against end
    logic    load_out;  // move result into output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] kind;
    logic       full;
    logic       pre_ok;
    logic       pos_zero;
    logic       lo_lt_hi;
    logic       lo_zero;
    logic       rd_gt;
    logic       out_busy;
  } status_t;

endpackage

// ----- rtl/core/pcrc_dpath.sv -----
// Datapath: region table memories, count, search and insert pointers,
// result and output registers. Depends on pcrc_pkg.
`timescale 1ns / 1ps

module pcrc_dpath
  import pcrc_pkg::*;
#(
  parameter int MAX_REGIONS = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output status_t   status,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);

  // Region table, sorted by start
  logic [63:0] start_mem [MAX_REGIONS];
  logic [63:0] end_mem   [MAX_REGIONS];

  logic [63:0] rd_start;
  logic [63:0] rd_end;

  // Captured request
  logic [1:0]  op_kind;
  logic [63:0] op_start;
  logic [63:0] op_end;
  logic [63:0] op_value;

  logic [CW-1:0] count;
  logic [CW-1:0] pos;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic          res_ptr;
  logic          res_full;

  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;
  logic [CW-1:0] pos_m1;
  logic [CW-1:0] lo_m1;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [63:0]   wr_start;
  logic [63:0]   wr_end;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CW:1];
  assign pos_m1  = pos - CW'(1);
  assign lo_m1   = lo - CW'(1);

  // Read address select
  always_comb begin
    case (cmd.rd_src)
      RD_POS_M1: rd_addr = pos_m1[AW-1:0];
      RD_MID:    rd_addr = mid[AW-1:0];
      RD_LO_M1:  rd_addr = lo_m1[AW-1:0];
      default:   rd_addr = mid[AW-1:0];
    endcase
  end

  // Write port: shifted entry or the new region
  assign wr_en    = cmd.shift | cmd.put;
  assign wr_start = cmd.shift ? rd_start : op_start;
  assign wr_end   = cmd.shift ? rd_end   : op_end;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_mem[pos[AW-1:0]] <= wr_start;
      end_mem[pos[AW-1:0]]   <= wr_end;
    end
    if (cmd.rd_en) begin
      rd_start <= start_mem[rd_addr];
      rd_end   <= end_mem[rd_addr];
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.put) begin
      count <= count + CW'(1);
    end
  end

  // Request capture, pointers and result bits
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_kind  <= in_data.kind;
      op_start <= in_data.region_start;
      op_end   <= in_data.region_end;
      op_value <= in_data.query_value;
      pos      <= count;
      lo       <= '0;
      hi       <= count;
      res_ptr  <= 1'b0;
      res_full <= 1'b0;
    end else begin
      if (cmd.set_full) begin
        res_full <= 1'b1;
      end
      if (cmd.shift) begin
        pos <= pos_m1;
      end
      if (cmd.step) begin
        if (rd_start <= op_value) begin
          lo <= mid + CW'(1);
        end else begin
          hi <= mid;
        end
      end
      // start <= value is already known for this entry
      if (cmd.set_ptr) begin
        res_ptr <= (op_value < rd_end);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.is_pointer <= res_ptr;
      out_data.table_full <= res_full;
    end
  end

  // Status back to the controller
  always_comb begin
    status.kind     = op_kind;
    status.full     = (count == CW'(MAX_REGIONS));
    status.pre_ok   = (op_value != 64'd0) && !op_value[0] &&
                      (((op_value & HIGH_MASK) == 64'd0) ||
                       ((op_value & HIGH_MASK) == HIGH_MASK));
    status.pos_zero = (pos == '0);
    status.lo_lt_hi = (lo < hi);
    status.lo_zero  = (lo == '0);
    status.rd_gt    = (rd_start > op_start);
    status.out_busy = out_valid & ~out_ready;
  end

endmodule

// ----- rtl/core/pcrc_ctrl.sv -----
// Controller state machine: sequences clear, sorted insert and binary
// search over the region table. Depends on pcrc_pkg.
`timescale 1ns / 1ps

module pcrc_ctrl
  import pcrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DISPATCH = 9'b000000010,
    S_ADD_RD   = 9'b000000100,
    S_ADD_CMP  = 9'b000001000,
    S_ADD_PUT  = 9'b000010000,
    S_SRCH_RD  = 9'b000100000,
    S_SRCH_CMP = 9'b001000000,
    S_CHK      = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_src = RD_MID;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status.kind)
          KIND_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_DONE;
          end
          KIND_ADD: begin
            if (status.full) begin
              cmd.set_full = 1'b1;
              state_next   = S_DONE;
            end else begin
              state_next = S_ADD_RD;
            end
          end
          KIND_CLASSIFY: begin
            state_next = status.pre_ok ? S_SRCH_RD : S_DONE;
          end
          default: state_next = S_DONE;
        endcase
      end
      // Walk down from the top, moving larger starts up one slot
      S_ADD_RD: begin
        if (status.pos_zero) begin
          state_next = S_ADD_PUT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_POS_M1;
          state_next = S_ADD_CMP;
        end
      end
      S_ADD_CMP: begin
        if (status.rd_gt) begin
          cmd.shift  = 1'b1;
          state_next = S_ADD_RD;
        end else begin
          state_next = S_ADD_PUT;
        end
      end
      S_ADD_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_DONE;
      end
      // Upper bound search: lo ends at count of starts <= value
      S_SRCH_RD: begin
        if (status.lo_lt_hi) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_MID;
          state_next = S_SRCH_CMP;
        end else if (status.lo_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_LO_M1;
          state_next = S_CHK;
        end
      end
      S_SRCH_CMP: begin
        cmd.step   = 1'b1;
        state_next = S_SRCH_RD;
      end
      S_CHK: begin
        cmd.set_ptr = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/pointer_candidate_range_check.sv -----
// Top level of the pointer candidate range check.
// Instantiates pcrc_ctrl and pcrc_dpath; depends on pcrc_pkg.
`timescale 1ns / 1ps

// Holds up to MAX_REGIONS address regions sorted by start in a pair of
// single-write, single-read memories, and answers one request at a time
// with exactly one result transfer. A clear, an unused kind, a rejected
// add, or a classify whose word fails the nonzero/even/canonical test
// goes from dispatch straight to the output register load. An accepted
// add moves each entry with a start above the new one up one slot via the
// memory read port (a read and a compare each), then writes the new
// region; the final read and compare are skipped when the new start is
// below every stored start or the table is empty. A passing classify runs
// binary search probes (about log2(count)+1, at most 7 for 64 entries),
// each a memory read and a compare, then reads the entry below lo and
// checks the word against its end, skipped when no start is <= the word.
// The input is ready again in the cycle after the output register load,
// and a result still waiting in the output register holds the block until
// it is taken. No clearing pass is needed after reset; count bounds reads.
module pointer_candidate_range_check
  import pcrc_pkg::*;
#(
  parameter int MAX_REGIONS = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cmd_t    cmd;
  status_t status;

  pcrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pcrc_dpath #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for pointer_candidate_range_check: directed, full-table,
// backpressure and random request streams checked against a local table model.
// Depends on pcrc_pkg and the pointer_candidate_range_check RTL.
`timescale 1ns / 1ps

module testbench;
  import pcrc_pkg::*;

  localparam int          TABLE_DEPTH  = 64;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;
  localparam int          RANDOM_ITEMS = 1250;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 160;
  localparam int          LIMIT_CYCLES = 1_000_000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Local copy of the region table
  logic [63:0] tbl_start [TABLE_DEPTH];
  logic [63:0] tbl_end   [TABLE_DEPTH];
  int          tbl_count = 0;

  out_item_t   pending_results[$];
  int          errors      = 0;
  int          items_sent  = 0;
  int          results_got = 0;
  int          cycle_count = 0;
  bit          idle_on     = 1'b1;
  bit          hold_req    = 1'b0;
  bit          hold_off    = 1'b0;

  pointer_candidate_range_check #(
    .MAX_REGIONS (TABLE_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Run limit
  initial begin : watchdog
    wait (cycle_count >= LIMIT_CYCLES);
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Table model
  // ---------------------------------------------------------------------------

  // Region with greatest start not above addr; last of equal starts wins
  function automatic logic region_hit(logic [63:0] addr);
    int hit;
    hit = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_start[i] <= addr) hit = i;
      else break;
    end
    if (hit < 0) return 1'b0;
    return (addr >= tbl_start[hit]) && (addr < tbl_end[hit]);
  endfunction

  function automatic logic likely_pointer(logic [63:0] v);
    logic [63:0] hi;
    hi = v & HIGH_MASK;
    if (v == 64'd0 || v[0]) return 1'b0;
    if (hi != 64'd0 && hi != HIGH_MASK) return 1'b0;
    return region_hit(v);
  endfunction

  // Sorted insert after equal starts; returns 1 when the table is full
  function automatic logic insert_region(logic [63:0] s, logic [63:0] e);
    int pos;
    if (tbl_count >= TABLE_DEPTH) return 1'b1;
    pos = tbl_count;
    while (pos > 0 && tbl_start[pos-1] > s) pos--;
    for (int j = tbl_count; j > pos; j--) begin
      tbl_start[j] = tbl_start[j-1];
      tbl_end[j]   = tbl_end[j-1];
    end
    tbl_start[pos] = s;
    tbl_end[pos]   = e;
    tbl_count++;
    return 1'b0;
  endfunction

  // Applies one request to the model and returns the result it causes
  function automatic out_item_t apply_request(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.kind)
      KIND_CLEAR:    tbl_count = 0;
      KIND_ADD:      r.table_full = insert_region(it.region_start, it.region_end);
      KIND_CLASSIFY: r.is_pointer = likely_pointer(it.query_value);
      default:       r = '0;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Addresses in low canonical, high canonical, a dense cluster, or anywhere
  function automatic logic [63:0] rand_addr();
    logic [63:0] r;
    r = rand64();
    case ($urandom_range(0, 3))
      0: r[63:48] = 16'h0000;
      1: r[63:48] = 16'hffff;
      2: r = 64'h0000_5555_0000_0000 + 64'($urandom_range(0, 16'hffff)) * 64'd16;
      default: ;
    endcase
    return r;
  endfunction

  // Words near stored regions most of the time, so lookups hit and miss edges
  function automatic logic [63:0] pick_query();
    logic [63:0] s;
    logic [63:0] e;
    logic [63:0] q;
    int          idx;
    if (tbl_count > 0 && $urandom_range(0, 9) < 7) begin
      idx = $urandom_range(0, tbl_count - 1);
      s = tbl_start[idx];
      e = tbl_end[idx];
      case ($urandom_range(0, 5))
        0: q = s;
        1: q = e;
        2: q = e - 64'd2;
        3: q = s - 64'd2;
        default: begin
          if (e > s && (e - s) < 64'h1_0000_0000)
            q = s + 64'($urandom_range(0, 32'(e - s)));
          else
            q = s + 64'($urandom);
        end
      endcase
      if ($urandom_range(0, 9) != 0) q[0] = 1'b0;
    end else begin
      case ($urandom_range(0, 3))
        0: q = 64'd0;
        1: q = rand64();
        default: q = rand_addr() & ~64'd1;
      endcase
    end
    return q;
  endfunction

  // One input transfer; the expected result is queued at acceptance
  task automatic send_item(logic [1:0] kind, logic [63:0] rs, logic [63:0] re,
                           logic [63:0] qv);
    in_item_t it;
    int       gap;
    it.kind         = kind;
    it.region_start = rs;
    it.region_end   = re;
    it.query_value  = qv;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results = {pending_results, apply_request(it)};
    items_sent++;
  endtask

  task automatic send_add(logic [63:0] s, logic [63:0] e);
    send_item(KIND_ADD, s, e, rand64());
  endtask

  task automatic send_query(logic [63:0] q);
    send_item(KIND_CLASSIFY, rand64(), rand64(), q);
  endtask

  task automatic send_clear();
    send_item(KIND_CLEAR, rand64(), rand64(), rand64());
  endtask

  // Random region: short, empty, inverted, random end, or a repeated start
  task automatic send_random_add();
    logic [63:0] s;
    logic [63:0] e;
    if (tbl_count > 0 && $urandom_range(0, 4) == 0)
      s = tbl_start[$urandom_range(0, tbl_count - 1)];
    else
      s = rand_addr();
    case ($urandom_range(0, 9))
      0: e = s;
      1: e = s - 64'($urandom_range(1, 16'h4000));
      2: e = rand64();
      default: e = s + 64'($urandom_range(0, 16'h4000));
    endcase
    send_add(s, e);
  endtask

  // Idle the input, wait for every result, then let the block settle
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(string field, int got, int want);
    $display("ERROR result %0d %s: got %0d expected %0d", results_got, field, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, long hold on request, field checks
  // ---------------------------------------------------------------------------

  initial begin : hold_timer
    forever begin
      wait (hold_req);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off = 1'b0;
      hold_req = 1'b0;
    end
  end

  initial begin : result_sink
    int        gap;
    out_item_t want;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0 || hold_off) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.is_pointer !== want.is_pointer)
          report_mismatch("is_pointer", out_data.is_pointer, want.is_pointer);
        if (out_data.table_full !== want.table_full)
          report_mismatch("table_full", out_data.table_full, want.table_full);
      end
      results_got++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Edges of regions, equal starts, empty and inverted regions, canonical forms
  task automatic test_directed();
    idle_on = 1'b1;
    send_query(64'h1000);                          // empty table
    send_add(64'h1000, 64'h2000);
    send_query(64'h1000);                          // first address
    send_query(64'h1ffe);
    send_query(64'h2000);                          // exclusive end
    send_query(64'h0ffe);                          // below all regions
    send_add(64'h1000, 64'h1800);                  // equal start goes after
    send_query(64'h1900);                          // last equal start decides
    send_query(64'h1001);                          // odd word
    send_add(64'h5000, 64'h4000);                  // inverted
    send_query(64'h5000);
    send_add(64'h6000, 64'h6000);                  // empty
    send_query(64'h6000);
    send_add(64'hffff_8000_0000_0000, 64'hffff_ffff_ffff_ffff);
    send_query(64'hffff_ffff_ffff_fffe);           // high canonical
    send_query(64'hffff_ffff_ffff_ffff);
    send_add(64'h0001_0000_0000_0000, 64'h0002_0000_0000_0000);
    send_query(64'h0001_0000_0000_1000);           // not canonical
    send_query(64'd0);
    send_add(64'hffff_ffff_ffff_ffff, 64'd0);
    send_item(KIND_UNUSED, rand64(), rand64(), rand64());
    send_query(64'h1000);
    send_clear();
    send_query(64'h1000);
    settle();
  endtask

  // Fill in descending start order (every add moves all entries), then overflow
  task automatic test_table_full();
    logic [63:0] s;
    idle_on = 1'b1;
    send_clear();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      s = 64'h10_0000 + 64'(TABLE_DEPTH - 1 - i) * 64'h1000;
      send_add(s, s + 64'h800);
    end
    send_add(64'h0, 64'hffff_ffff_ffff_ffff);      // rejected
    send_query(64'h10_0400);
    send_query(64'h10_0000 + 64'(TABLE_DEPTH - 1) * 64'h1000 + 64'h7fe);
    send_query(64'h10_0900);
    send_add(64'h20_0000, 64'h20_1000);            // rejected again
    send_clear();
    send_add(64'h20_0000, 64'h20_1000);
    send_query(64'h20_0000);
    settle();
  endtask

  // Output held off while requests keep coming, so the input must stall
  task automatic test_backpressure();
    idle_on  = 1'b0;
    send_clear();
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 0) send_random_add();
      else            send_query(pick_query());
    end
    settle();
    idle_on = 1'b1;
  endtask

  // Mostly clear / fill / classify sequences with random content, some noise
  task automatic test_random();
    int target;
    int n_add;
    int n_query;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) != 0) send_clear();
      n_add = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 10);
      for (int k = 0; k < n_add; k++) begin
        send_random_add();
        if ($urandom_range(0, 6) == 0) send_query(pick_query());
      end
      n_query = $urandom_range(4, 24);
      for (int k = 0; k < n_query; k++) begin
        case ($urandom_range(0, 19))
          0:       send_item(KIND_UNUSED, rand64(), rand64(), rand64());
          1:       send_item(2'($urandom_range(0, 3)), rand64(), rand64(), rand64());
          default: send_query(pick_query());
        endcase
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin : main
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_backpressure();
    test_random();
    settle();
    if (pending_results.size() != 0)
      report_mismatch("results missing", 0, pending_results.size());
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/pcrc_pkg.sv
rtl/core/pcrc_dpath.sv
rtl/core/pcrc_ctrl.sv
rtl/core/pointer_candidate_range_check.sv
bench/testbench.sv
